// ===== hw/rtl/bsort_pkg.sv =====
package bsort_pkg;

  localparam int VALUE_W  = 12;
  localparam int USIZE_W  = 13;
  localparam int STATUS_W = 2;
  localparam int POS_W    = USIZE_W + 1;

  localparam logic [USIZE_W-1:0] USIZE_RESET = USIZE_W'(4096);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_TAKE   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND  = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/bsort_if.sv =====
interface bsort_req_if
  import bsort_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface bsort_rsp_if
  import bsort_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  sorted_value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output sorted_value, output status, input ready);
  modport sink   (input valid, input sorted_value, input status, output ready);
endinterface

// ===== hw/rtl/bsort_mem.sv =====
module bsort_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bsort_ffs.sv =====
module bsort_ffs #(
  parameter int WIDTH = 8,
  parameter int IDX_W = $clog2(WIDTH)
) (
  input  logic [WIDTH-1:0] vec,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  always_comb begin
    found = |vec;
    idx   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/bitmap_set_sorter_unit.sv =====
// Channel  Dir   Payload                        Transaction
// req      in    req_type, value                valid && ready
// rsp      out   sorted_value, status           valid && ready
// cfg      in    cfg_wdata (universe_size)      cfg_we
//
// Insert: accept, address fix-up, then read-modify-write; a reject answers at accept.
// Take: for each bit-store word visited, a read, then a test and write back; the scan
//   answers empty when it runs off the universe end.
// Reset: clearing pass over every bit-store word; req.ready stays low meanwhile.
// A new transaction is taken in the idle state once the result register is empty or draining.
module bitmap_set_sorter_unit
  import bsort_pkg::*;
#(
  parameter int UNIVERSE  = 4096,
  parameter int WORD_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [USIZE_W-1:0] cfg_wdata,
  bsort_req_if.sink          req,
  bsort_rsp_if.source        rsp
);

  localparam int DEPTH     = (UNIVERSE + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int RECIP     = (1 << VALUE_W) / WORD_BITS;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = VALUE_W + RECIP_W;
  localparam int USIZE_MAX = (1 << USIZE_W) - 1;
  localparam int UNI_CAP_I = (UNIVERSE < USIZE_MAX) ? UNIVERSE : USIZE_MAX;

  localparam logic [POS_W-1:0]     UNI_CAP  = POS_W'(UNI_CAP_I);
  localparam logic [RECIP_W-1:0]   RECIP_V  = RECIP_W'(RECIP);
  localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);
  localparam logic [ADDR_W-1:0]    LAST_ADR = ADDR_W'(DEPTH - 1);
  localparam logic [BIT_W-1:0]     LAST_BIT = BIT_W'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_ADDR,
    S_INS_WR,
    S_TK_RD,
    S_TK_CHK
  } state_t;

  state_t               state;
  logic [USIZE_W-1:0]   usize;
  logic [ADDR_W-1:0]    clr_addr;
  logic [VALUE_W-1:0]   ins_value;
  logic [ADDR_W-1:0]    ins_word;
  logic [BIT_W-1:0]     ins_bit;
  logic [POS_W-1:0]     cur_pos;
  logic [ADDR_W-1:0]    cur_word;
  logic [BIT_W-1:0]     cur_bit;
  logic                 rsp_valid;
  logic [VALUE_W-1:0]   rsp_value;
  status_t              rsp_status;

  logic [POS_W-1:0]     limit;
  logic                 req_fire;
  logic [PROD_W-1:0]    prod;
  logic [ADDR_W-1:0]    q_est;
  logic [VALUE_W:0]     ins_rem;
  logic [ADDR_W-1:0]    ins_word_next;
  logic [BIT_W-1:0]     ins_bit_next;
  logic [POS_W-1:0]     base;
  logic [WORD_BITS-1:0] masked;
  logic                 hit;
  logic [BIT_W-1:0]     hit_idx;
  logic [POS_W-1:0]     fpos;
  logic                 take_ok;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  assign limit = ({1'b0, usize} < UNI_CAP) ? {1'b0, usize} : UNI_CAP;

  assign req.ready    = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign req_fire     = req.valid && req.ready;
  assign rsp.valid    = rsp_valid;
  assign rsp.sorted_value = rsp_value;
  assign rsp.status   = rsp_status;

  assign prod  = PROD_W'(req.value) * PROD_W'(RECIP_V);
  assign q_est = ADDR_W'(prod >> VALUE_W);

  always_comb begin
    ins_rem = {1'b0, ins_value} - (VALUE_W + 1)'(ins_word * WORD_BITS);
    if (ins_rem >= (VALUE_W + 1)'(WORD_BITS)) begin
      ins_word_next = ins_word + ADDR_W'(1);
      ins_bit_next  = BIT_W'(ins_rem - (VALUE_W + 1)'(WORD_BITS));
    end else begin
      ins_word_next = ins_word;
      ins_bit_next  = BIT_W'(ins_rem);
    end
  end

  assign base    = cur_pos - POS_W'(cur_bit);
  assign masked  = mem_rdata & ({WORD_BITS{1'b1}} << cur_bit);
  assign fpos    = base + POS_W'(hit_idx);
  assign take_ok = hit && (fpos < limit);

  bsort_ffs #(
    .WIDTH (WORD_BITS),
    .IDX_W (BIT_W)
  ) u_ffs (
    .vec   (masked),
    .found (hit),
    .idx   (hit_idx)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_word;
    mem_wdata = '0;
    mem_raddr = cur_word;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_INS_ADDR: begin
        mem_raddr = ins_word_next;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ins_word;
        mem_wdata = mem_rdata | (WORD_ONE << ins_bit);
      end
      S_TK_CHK: begin
        mem_we    = take_ok;
        mem_wdata = mem_rdata & ~(WORD_ONE << hit_idx);
      end
      default: begin
      end
    endcase
  end

  bsort_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      usize      <= USIZE_RESET;
      clr_addr   <= '0;
      cur_pos    <= '0;
      cur_word   <= '0;
      cur_bit    <= '0;
      rsp_valid  <= 1'b0;
      rsp_value  <= '0;
      rsp_status <= ST_FOUND;
    end else begin
      if (cfg_we) begin
        usize <= cfg_wdata;
      end
      if (rsp_valid && rsp.ready && !req_fire) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            if (req.req_type == REQ_TAKE) begin
              rsp_valid <= 1'b0;
              state     <= S_TK_RD;
            end else if ({2'b0, req.value} >= limit) begin
              rsp_valid  <= 1'b1;
              rsp_value  <= '0;
              rsp_status <= ST_REJECT;
            end else begin
              rsp_valid <= 1'b0;
              ins_value <= req.value;
              ins_word  <= q_est;
              state     <= S_INS_ADDR;
            end
          end
        end
        S_INS_ADDR: begin
          ins_word <= ins_word_next;
          ins_bit  <= ins_bit_next;
          state    <= S_INS_WR;
        end
        S_INS_WR: begin
          state <= S_IDLE;
        end
        S_TK_RD: begin
          if (cur_pos >= limit) begin
            cur_pos    <= '0;
            cur_word   <= '0;
            cur_bit    <= '0;
            rsp_valid  <= 1'b1;
            rsp_value  <= '0;
            rsp_status <= ST_EMPTY;
            state      <= S_IDLE;
          end else begin
            state <= S_TK_CHK;
          end
        end
        S_TK_CHK: begin
          if (!hit) begin
            cur_pos  <= base + POS_W'(WORD_BITS);
            cur_word <= cur_word + ADDR_W'(1);
            cur_bit  <= '0;
            state    <= S_TK_RD;
          end else if (take_ok) begin
            cur_pos <= fpos + POS_W'(1);
            if (hit_idx == LAST_BIT) begin
              cur_word <= cur_word + ADDR_W'(1);
              cur_bit  <= '0;
            end else begin
              cur_bit <= hit_idx + BIT_W'(1);
            end
            rsp_valid  <= 1'b1;
            rsp_value  <= fpos[VALUE_W-1:0];
            rsp_status <= ST_FOUND;
            state      <= S_IDLE;
          end else begin
            cur_pos    <= '0;
            cur_word   <= '0;
            cur_bit    <= '0;
            rsp_valid  <= 1'b1;
            rsp_value  <= '0;
            rsp_status <= ST_EMPTY;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/bitmap_sort_check.sv =====
module bitmap_sort_check
  import bsort_pkg::*;
#(
  parameter int UNIVERSE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [USIZE_W-1:0] cfg_wdata,
  bsort_req_if               req,
  bsort_rsp_if               rsp,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } sort_answer_t;

  bit                 present [UNIVERSE];
  logic [USIZE_W:0]   cursor;
  logic [USIZE_W-1:0] universe;
  sort_answer_t       answers [$];
  int                 fails;

  function automatic bit bitmap_apply(input logic kind, input logic [VALUE_W-1:0] v,
                                      output sort_answer_t ans);
    int lim;
    int pos;
    lim = (universe < UNIVERSE) ? int'(universe) : UNIVERSE;
    ans = '{value: '0, status: ST_FOUND};
    if (kind == REQ_INSERT) begin
      if (int'(v) >= lim) begin
        ans.status = ST_REJECT;
        return 1'b1;
      end
      present[v] = 1'b1;
      return 1'b0;
    end
    pos = int'(cursor);
    while (pos < lim && !present[pos]) pos++;
    if (pos < lim) begin
      present[pos] = 1'b0;
      cursor = (USIZE_W + 1)'(pos + 1);
      ans.value = VALUE_W'(pos);
    end else begin
      cursor = '0;
      ans.status = ST_EMPTY;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    sort_answer_t want;
    if (rst) begin
      foreach (present[i]) present[i] = 1'b0;
      cursor = '0;
      universe = USIZE_RESET;
      answers.delete();
      fails = 0;
    end else begin
      if (cfg_we) universe = cfg_wdata;
      if (req.valid && req.ready) begin
        if (bitmap_apply(req.req_type, req.value, want)) answers = {answers, want};
      end
      if (rsp.valid && rsp.ready) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual value=%0d status=%0d",
                   $time, rsp.sorted_value, rsp.status);
          fails++;
        end else begin
          want = answers.pop_front();
          if (rsp.sorted_value !== want.value || rsp.status !== want.status) begin
            $display("%0t: mismatch, expected value=%0d status=%0d, actual value=%0d status=%0d",
                     $time, want.value, want.status, rsp.sorted_value, rsp.status);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= answers.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import bsort_pkg::*;

  localparam int UNIVERSE    = 4096;
  localparam int QUIET_LIMIT = 10000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [USIZE_W-1:0] cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  bit                 hold_request;
  int                 quiet_cycles = 0;

  bsort_req_if req_ch ();
  bsort_rsp_if rsp_ch ();

  bitmap_set_sorter_unit #(
    .UNIVERSE (UNIVERSE),
    .WORD_BITS(8)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  bitmap_sort_check #(
    .UNIVERSE(UNIVERSE)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic kind, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_universe(input logic [USIZE_W-1:0] usize);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= usize;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int count, input logic [USIZE_W-1:0] usize, input bit hold);
    int                 lim;
    int                 done;
    int                 burst;
    logic [VALUE_W-1:0] v;
    set_universe(usize);
    if (hold) hold_request = 1'b1;
    lim = (usize < UNIVERSE) ? int'(usize) : UNIVERSE;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 8);
      done += burst;
      repeat (burst) begin
        if (lim > 0 && $urandom_range(9) != 0) v = VALUE_W'($urandom_range(lim - 1));
        else v = VALUE_W'($urandom);
        send(REQ_INSERT, v);
      end
      burst = $urandom_range(1, 10);
      done += burst;
      repeat (burst) send(REQ_TAKE, VALUE_W'($urandom));
    end
  endtask

  initial begin
    logic [USIZE_W-1:0] sizes [12];
    sizes = '{13'd4096, 13'd16, 13'd1, 13'h1FFF, 13'd200, 13'd7,
              13'd4096, 13'd64, 13'd33, 13'd1000, 13'd0, 13'd8};
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.value    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send(REQ_INSERT, 12'd4095);
    send(REQ_INSERT, 12'd0);
    send(REQ_INSERT, 12'd0);
    send(REQ_TAKE, 12'd0);
    send(REQ_TAKE, 12'hFFF);
    send(REQ_TAKE, 12'd0);
    send(REQ_TAKE, 12'd0);

    set_universe(13'd0);
    send(REQ_INSERT, 12'd5);
    send(REQ_TAKE, 12'd0);

    set_universe(13'h1FFF);
    send(REQ_INSERT, 12'd100);
    send(REQ_INSERT, 12'd4095);
    send(REQ_TAKE, 12'd0);

    // shrink below the cursor, take from there, then insert under the smaller universe
    set_universe(13'd50);
    send(REQ_TAKE, 12'd0);
    send(REQ_INSERT, 12'd60);
    send(REQ_INSERT, 12'd10);
    send(REQ_INSERT, 12'd30);
    send(REQ_TAKE, 12'd0);
    send(REQ_INSERT, 12'd5);
    send(REQ_TAKE, 12'd0);
    send(REQ_TAKE, 12'd0);
    send(REQ_TAKE, 12'd0);

    set_universe(13'd1);
    send(REQ_INSERT, 12'd0);
    send(REQ_INSERT, 12'd1);
    send(REQ_TAKE, 12'd0);
    send(REQ_TAKE, 12'd0);

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 10;
        recv_idle_pct = 67;
      end else if (p < 8) begin
        send_idle_pct = 67;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 10) sizes[p] = USIZE_W'($urandom_range(2, 300));
      random_phase(170, sizes[p], p == 9);
    end

    settle();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
